// File: hw/rtl/polyphase_pulse_shaping_qam_modulator_top_defines.svh
// ----------------------------------------------------------------------------
// Polyphase QAM modulator assertion macros
// Shared property forms for the modulator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef POLYPHASE_PULSE_SHAPING_QAM_MODULATOR_TOP_DEFINES_SVH
`define POLYPHASE_PULSE_SHAPING_QAM_MODULATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPSQAM_ASSERT_HOLDS(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPSQAM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ppsqam_pkg.sv
// ----------------------------------------------------------------------------
// Polyphase QAM modulator package
// Command and register codes, sine constants and the mixer interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package ppsqam_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CARRIER_W  = 32;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Input command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BAUD_INCREMENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN    = 2'd2;

    // Quarter-wave odd polynomial coefficients, Q2.30
    localparam logic [30:0] SIN_A = 31'd1686629713;
    localparam logic [29:0] SIN_B = 30'd688904866;
    localparam logic [26:0] SIN_C = 27'd76016977;

    typedef struct packed {
        logic                 start;
        logic [CARRIER_W-1:0] phase;
    } mix_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] amplitude;
    } mix_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/ppsqam_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppsqam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/ppsqam_mixer.sv
// ----------------------------------------------------------------------------
// Carrier mixer and output scaler
// Builds cosine and sine of the carrier phase by polynomial, mixes the
// filtered symbol and applies the gain, all through one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module ppsqam_mixer #(
    parameter int Y_W = 23
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire ppsqam_pkg::mix_req_t                req,
    input  wire logic signed [Y_W-1:0]               y_re,
    input  wire logic signed [Y_W-1:0]               y_im,
    input  wire logic [ppsqam_pkg::GAIN_W-1:0]       gain,
    output ppsqam_pkg::mix_rsp_t                     rsp
);

    localparam int P_W = Y_W + 16;   // y times carrier
    localparam int M_W = P_W + 1;    // mixed value
    localparam int H_W = M_W - 1;    // upper part times gain
    localparam int T_W = M_W + 17;   // scaled total
    localparam int A_W = T_W - 35;   // amplitude before saturation
    localparam logic signed [A_W-1:0] AMP_MAX = A_W'(32767);
    localparam logic signed [A_W-1:0] AMP_MIN = A_W'(-32768);

    typedef enum logic [10:0] {
        MX_IDLE = 11'b000_0000_0001,
        MX_SQ   = 11'b000_0000_0010,
        MX_CX   = 11'b000_0000_0100,
        MX_TX   = 11'b000_0000_1000,
        MX_UX   = 11'b000_0001_0000,
        MX_RND  = 11'b000_0010_0000,
        MX_MRE  = 11'b000_0100_0000,
        MX_MIM  = 11'b000_1000_0000,
        MX_GHI  = 11'b001_0000_0000,
        MX_GLO  = 11'b010_0000_0000,
        MX_SAT  = 11'b100_0000_0000
    } mx_state_t;

    mx_state_t state_reg, state_next;
    logic      done_reg;

    logic [31:0]          phase_reg;
    logic                 sine_pass_reg;
    logic                 neg_reg;
    logic [16:0]          x_reg;
    logic [16:0]          x2_reg;
    logic [29:0]          t_reg;
    logic [30:0]          u_reg;
    logic [31:0]          s_reg;
    logic signed [15:0]   cos_reg;
    logic signed [15:0]   sin_reg;
    logic [P_W-1:0]       pr_reg;
    logic [M_W-1:0]       m_reg;
    logic [H_W-1:0]       gh_reg;
    logic [33:0]          gl_reg;
    logic signed [15:0]   amp_reg;

    logic signed [31:0]   mul_a;
    logic signed [17:0]   mul_b;
    logic signed [49:0]   prod;
    logic [31:0]          cos_phase;
    logic [32:0]          rnd_sum;
    logic [17:0]          rnd_val;
    logic [15:0]          cap_val;
    logic [15:0]          trig_val;
    logic [M_W-1:0]       m_next;
    logic [T_W-1:0]       total;
    logic signed [A_W-1:0] amp_full;
    logic signed [15:0]   amp_next;

    // Quarter-wave argument: fold the phase into 0..65536
    function automatic logic [16:0] quarter_arg(input logic [31:0] p);
        logic [16:0] f;
        f = {1'b0, p[29:14]};
        if (p[30]) begin
            quarter_arg = 17'h10000 - f;
        end else begin
            quarter_arg = f;
        end
    endfunction

    assign cos_phase = req.phase + 32'h4000_0000;

    // Shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            MX_SQ: begin
                mul_a = {15'd0, x_reg};
                mul_b = {1'b0, x_reg};
            end
            MX_CX: begin
                mul_a = {5'd0, ppsqam_pkg::SIN_C};
                mul_b = {1'b0, x2_reg};
            end
            MX_TX: begin
                mul_a = {2'd0, t_reg};
                mul_b = {1'b0, x2_reg};
            end
            MX_UX: begin
                mul_a = {1'b0, u_reg};
                mul_b = {1'b0, x_reg};
            end
            MX_MRE: begin
                mul_a = {{(32-Y_W){y_re[Y_W-1]}}, y_re};
                mul_b = {{2{cos_reg[15]}}, cos_reg};
            end
            MX_MIM: begin
                mul_a = {{(32-Y_W){y_im[Y_W-1]}}, y_im};
                mul_b = {{2{sin_reg[15]}}, sin_reg};
            end
            MX_GHI: begin
                mul_a = {{(32-(M_W-18)){m_reg[M_W-1]}}, m_reg[M_W-1:18]};
                mul_b = {2'd0, gain};
            end
            MX_GLO: begin
                mul_a = {14'd0, m_reg[17:0]};
                mul_b = {2'd0, gain};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Round the quarter sine to Q1.15, cap, then apply the half-wave sign
    always_comb begin
        rnd_sum  = {1'b0, s_reg} + 33'd16384;
        rnd_val  = rnd_sum[32:15];
        cap_val  = (rnd_val > 18'd32767) ? 16'd32767 : rnd_val[15:0];
        trig_val = neg_reg ? (~cap_val) + 16'd1 : cap_val;
    end

    assign m_next = {pr_reg[P_W-1], pr_reg} - {prod[P_W-1], prod[P_W-1:0]};

    always_comb begin
        total    = {gh_reg, 18'd0} + {{(T_W-34){1'b0}}, gl_reg} + (T_W'(1) << 34);
        amp_full = total[T_W-1:35];
        if (amp_full > AMP_MAX) begin
            amp_next = 16'sd32767;
        end else if (amp_full < AMP_MIN) begin
            amp_next = -16'sd32768;
        end else begin
            amp_next = amp_full[15:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            MX_IDLE: if (req.start) state_next = MX_SQ;
            MX_SQ:   state_next = MX_CX;
            MX_CX:   state_next = MX_TX;
            MX_TX:   state_next = MX_UX;
            MX_UX:   state_next = MX_RND;
            MX_RND:  state_next = sine_pass_reg ? MX_MRE : MX_SQ;
            MX_MRE:  state_next = MX_MIM;
            MX_MIM:  state_next = MX_GHI;
            MX_GHI:  state_next = MX_GLO;
            MX_GLO:  state_next = MX_SAT;
            MX_SAT:  state_next = MX_IDLE;
            default: state_next = MX_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MX_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == MX_SAT);
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            MX_IDLE: begin
                if (req.start) begin
                    phase_reg     <= req.phase;
                    sine_pass_reg <= 1'b0;
                    x_reg         <= quarter_arg(cos_phase);
                    neg_reg       <= cos_phase[31];
                end
            end
            MX_SQ:  x2_reg <= prod[32:16];
            MX_CX:  t_reg  <= ppsqam_pkg::SIN_B - {2'd0, prod[43:16]};
            MX_TX:  u_reg  <= ppsqam_pkg::SIN_A - prod[46:16];
            MX_UX:  s_reg  <= prod[47:16];
            MX_RND: begin
                if (sine_pass_reg) begin
                    sin_reg <= trig_val;
                end else begin
                    cos_reg       <= trig_val;
                    sine_pass_reg <= 1'b1;
                    x_reg         <= quarter_arg(phase_reg);
                    neg_reg       <= phase_reg[31];
                end
            end
            MX_MRE: pr_reg <= prod[P_W-1:0];
            MX_MIM: m_reg  <= m_next;
            MX_GHI: gh_reg <= prod[H_W-1:0];
            MX_GLO: gl_reg <= prod[33:0];
            MX_SAT: amp_reg <= amp_next;
            default: begin
            end
        endcase
    end

    assign rsp.done      = done_reg;
    assign rsp.amplitude = amp_reg;

endmodule

`default_nettype wire

// File: hw/rtl/polyphase_pulse_shaping_qam_modulator_top.sv
// ----------------------------------------------------------------------------
// Polyphase pulse-shaping QAM modulator
// Baud-phase driven polyphase root-raised-cosine filter over a ring of past
// symbols, mixed with a DDS carrier, scaled, rounded and saturated.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake            Payload
//  s_       in   s_valid / s_ready    cmd, symbol_real, symbol_imag,
//                                     coeff_address, coeff_value
//  m_       out  m_valid / m_ready    amplitude, symbol_taken
//  cfg_     in   cfg_wr_en            cfg_index, cfg_wr_data
//
//  A load returns no result. A sample tick walks the taps, rounds the sums,
//  runs the mixer's shared multiplier (cosine, sine, mix, gain) and then loads
//  the output register. s_ready is high only while idle; a stalled m_ready
//  holds the next result in the mixer. Reset is synchronous, active low;
//  per-entry valid bits make the symbol ring read as zero until written, so no
//  clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polyphase_pulse_shaping_qam_modulator_top_defines.svh"

module polyphase_pulse_shaping_qam_modulator_top #(
    parameter int SETS = 16,
    parameter int TAPS = 32
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,

    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_cmd,
    input  wire logic signed [15:0]                     s_symbol_real,
    input  wire logic signed [15:0]                     s_symbol_imag,
    input  wire logic [8:0]                             s_coeff_address,
    input  wire logic signed [15:0]                     s_coeff_value,

    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [15:0]                          m_amplitude,
    output logic                                        m_symbol_taken,

    input  wire logic                                   cfg_wr_en,
    input  wire logic [ppsqam_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [ppsqam_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

    localparam int PH_W  = $clog2(SETS);
    localparam int INC_W = PH_W + 1;
    localparam int TAP_W = $clog2(TAPS);
    localparam int STORE = SETS * TAPS;
    localparam int CA_W  = $clog2(STORE);
    localparam int ACC_W = 32 + TAP_W;
    localparam int Y_W   = ACC_W - 14;
    localparam logic [CA_W-1:0]  TAPS_C   = CA_W'(TAPS);
    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAPS - 1);
    localparam logic [INC_W-1:0] SETS_C   = INC_W'(SETS);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MAC   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_MIX   = 5'b01000,
        ST_HOLD  = 5'b10000
    } state_t;

    // Control state
    state_t                                  state_reg, state_next;
    logic [4:0]                              baud_inc_reg;
    logic [ppsqam_pkg::CARRIER_W-1:0]        carrier_step_reg;
    logic [ppsqam_pkg::GAIN_W-1:0]           gain_reg;
    logic [PH_W-1:0]                         baud_phase_reg;
    logic [TAP_W-1:0]                        ring_pos_reg;
    logic [ppsqam_pkg::CARRIER_W-1:0]        carrier_phase_reg;
    logic [TAPS-1:0]                         ring_valid_reg;
    logic                                    issue_on_reg;
    logic                                    v1_reg;
    logic                                    v2_reg;
    logic [TAP_W-1:0]                        idx_reg;
    logic [TAP_W-1:0]                        rd_ptr_reg;
    logic [CA_W-1:0]                         cf_ptr_reg;
    logic                                    m_valid_reg;

    // Datapath
    logic                                    vb1_reg;
    logic signed [31:0]                      pr_re_reg;
    logic signed [31:0]                      pr_im_reg;
    logic signed [ACC_W-1:0]                 acc_re_reg;
    logic signed [ACC_W-1:0]                 acc_im_reg;
    logic signed [Y_W-1:0]                   y_re_reg;
    logic signed [Y_W-1:0]                   y_im_reg;
    logic [ppsqam_pkg::CARRIER_W-1:0]        phase_snap_reg;
    logic                                    taken_reg;
    logic signed [15:0]                      m_amplitude_reg;
    logic                                    m_symbol_taken_reg;

    logic                                    s_accept;
    logic                                    tick_acc;
    logic                                    load_we;
    logic [INC_W-1:0]                        inc;
    logic [INC_W-1:0]                        phase_sum;
    logic                                    take;
    logic [PH_W-1:0]                         phase_next;
    logic [PH_W-1:0]                         row;
    logic [CA_W-1:0]                         row_base;
    logic [TAP_W-1:0]                        pos_next;
    logic [TAP_W-1:0]                        rd_ptr_next;
    logic [31:0]                             ring_rd;
    logic [15:0]                             coef_rd;
    logic signed [15:0]                      sym_re;
    logic signed [15:0]                      sym_im;
    logic [ACC_W:0]                          rnd_re;
    logic [ACC_W:0]                          rnd_im;
    logic                                    out_load;
    ppsqam_pkg::mix_req_t                    mix_req;
    ppsqam_pkg::mix_rsp_t                    mix_rsp;

    assign s_accept = s_valid && s_ready;
    assign tick_acc = s_accept && (s_cmd == ppsqam_pkg::CMD_TICK);
    // Drop loads that fall beyond the coefficient store
    assign load_we  = s_accept && (s_cmd == ppsqam_pkg::CMD_LOAD)
                      && (int'(s_coeff_address) < STORE);

    // Advance the baud phase; a wrap takes the offered symbol
    always_comb begin
        inc        = (int'(baud_inc_reg) > SETS) ? SETS_C : INC_W'(baud_inc_reg);
        phase_sum  = {1'b0, baud_phase_reg} + inc;
        take       = (phase_sum >= SETS_C);
        phase_next = take ? PH_W'(phase_sum - SETS_C) : PH_W'(phase_sum);
        row        = PH_W'(SETS - 1) - phase_next;
        row_base   = CA_W'(row) * TAPS_C;
        if (take) begin
            pos_next = (ring_pos_reg == TAP_LAST) ? '0 : ring_pos_reg + 1'b1;
        end else begin
            pos_next = ring_pos_reg;
        end
        rd_ptr_next = (rd_ptr_reg == TAP_LAST) ? '0 : rd_ptr_reg + 1'b1;
    end

    // Symbol ring: real part high, imaginary part low
    ppsqam_ram #(
        .WIDTH (32),
        .DEPTH (TAPS)
    ) u_ring (
        .aclk  (aclk),
        .we    (tick_acc && take),
        .waddr (ring_pos_reg),
        .wdata ({s_symbol_real, s_symbol_imag}),
        .raddr (rd_ptr_reg),
        .rdata (ring_rd)
    );

    // Polyphase coefficient store, one row of TAPS per set
    ppsqam_ram #(
        .WIDTH (16),
        .DEPTH (STORE)
    ) u_coef (
        .aclk  (aclk),
        .we    (load_we),
        .waddr (CA_W'(s_coeff_address)),
        .wdata (s_coeff_value),
        .raddr (cf_ptr_reg),
        .rdata (coef_rd)
    );

    // Ring entries never written read as zero
    assign sym_re = vb1_reg ? $signed(ring_rd[31:16]) : 16'sd0;
    assign sym_im = vb1_reg ? $signed(ring_rd[15:0])  : 16'sd0;

    // Round the Q.27 sums half up to Q.12
    assign rnd_re = {acc_re_reg[ACC_W-1], acc_re_reg} + (ACC_W+1)'(16384);
    assign rnd_im = {acc_im_reg[ACC_W-1], acc_im_reg} + (ACC_W+1)'(16384);

    assign mix_req.start = (state_reg == ST_ROUND);
    assign mix_req.phase = phase_snap_reg;

    ppsqam_mixer #(
        .Y_W (Y_W)
    ) u_mixer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mix_req),
        .y_re    (y_re_reg),
        .y_im    (y_im_reg),
        .gain    (gain_reg),
        .rsp     (mix_rsp)
    );

    // Load the output register once the previous result has been transferred
    assign out_load = (state_reg == ST_HOLD) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (tick_acc) state_next = ST_MAC;
            ST_MAC:   if (!issue_on_reg && !v1_reg && !v2_reg) state_next = ST_ROUND;
            ST_ROUND: state_next = ST_MIX;
            ST_MIX:   if (mix_rsp.done) state_next = ST_HOLD;
            ST_HOLD:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            baud_inc_reg      <= 5'd1;
            carrier_step_reg  <= '0;
            gain_reg          <= 16'd256;
            baud_phase_reg    <= '0;
            ring_pos_reg      <= '0;
            carrier_phase_reg <= '0;
            ring_valid_reg    <= '0;
            issue_on_reg      <= 1'b0;
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            idx_reg           <= '0;
            rd_ptr_reg        <= '0;
            cf_ptr_reg        <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Configuration writes; unknown indexes are dropped
            if (cfg_wr_en) begin
                case (cfg_index)
                    ppsqam_pkg::CFG_BAUD_INCREMENT: baud_inc_reg     <= cfg_wr_data[4:0];
                    ppsqam_pkg::CFG_CARRIER_STEP:   carrier_step_reg <= cfg_wr_data;
                    ppsqam_pkg::CFG_OUTPUT_GAIN:    gain_reg         <= cfg_wr_data[15:0];
                    default: begin
                    end
                endcase
            end

            if (tick_acc) begin
                baud_phase_reg    <= phase_next;
                ring_pos_reg      <= pos_next;
                carrier_phase_reg <= carrier_phase_reg + carrier_step_reg;
                if (take) begin
                    ring_valid_reg[ring_pos_reg] <= 1'b1;
                end
                // Start the tap walk at the oldest symbol
                issue_on_reg <= 1'b1;
                idx_reg      <= '0;
                rd_ptr_reg   <= pos_next;
                cf_ptr_reg   <= row_base;
            end else if (issue_on_reg) begin
                idx_reg    <= idx_reg + 1'b1;
                rd_ptr_reg <= rd_ptr_next;
                cf_ptr_reg <= cf_ptr_reg + 1'b1;
                if (idx_reg == TAP_LAST) begin
                    issue_on_reg <= 1'b0;
                end
            end

            v1_reg <= issue_on_reg;
            v2_reg <= v1_reg;

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        vb1_reg <= ring_valid_reg[rd_ptr_reg];

        if (tick_acc) begin
            phase_snap_reg <= carrier_phase_reg;
            taken_reg      <= take;
        end

        // Multiply stage of the tap walk
        if (v1_reg) begin
            pr_re_reg <= sym_re * $signed(coef_rd);
            pr_im_reg <= sym_im * $signed(coef_rd);
        end

        // Accumulate stage; clear at the start of each tick
        if (tick_acc) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (v2_reg) begin
            acc_re_reg <= acc_re_reg + {{(ACC_W-32){pr_re_reg[31]}}, pr_re_reg};
            acc_im_reg <= acc_im_reg + {{(ACC_W-32){pr_im_reg[31]}}, pr_im_reg};
        end

        if (state_reg == ST_ROUND) begin
            y_re_reg <= rnd_re[ACC_W:15];
            y_im_reg <= rnd_im[ACC_W:15];
        end

        if (out_load) begin
            m_amplitude_reg    <= mix_rsp.amplitude;
            m_symbol_taken_reg <= taken_reg;
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_amplitude    = m_amplitude_reg;
    assign m_symbol_taken = m_symbol_taken_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `PPSQAM_ASSERT_HOLDS(a_ring_pos_range, aclk, aresetn, 1'b1, ring_pos_reg <= TAP_LAST, "ring position past the last tap")
    `PPSQAM_ASSERT_HOLDS(a_baud_phase_range, aclk, aresetn, 1'b1, int'(baud_phase_reg) < SETS, "baud phase reached the set count")
    `PPSQAM_ASSERT_HOLDS(a_mix_done_in_mix, aclk, aresetn, mix_rsp.done, state_reg == ST_MIX, "mixer finished outside the mix phase")
    `PPSQAM_ASSERT_HOLDS(a_walk_blocks_input, aclk, aresetn, issue_on_reg || v1_reg || v2_reg, !s_ready, "input ready during the tap walk")
    `PPSQAM_ASSERT_NEXT(a_tick_goes_busy, aclk, aresetn, tick_acc, !s_ready && issue_on_reg, "sample tick did not start the tap walk")

endmodule

`default_nettype wire
